// ----- hdl/lcbp_pkg.sv -----
package lcbp_pkg;

    typedef enum logic [1:0] {
        MODE_CMD = 2'd0,
        MODE_SET = 2'd1,
        MODE_MAP = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        SET_IDLE  = 2'd0,
        SET_LIGHT = 2'd1,
        SET_HIGH  = 2'd2,
        SET_LAST  = 2'd3
    } set_phase_t;

    typedef enum logic [1:0] {
        MAP_IDLE  = 2'd0,
        MAP_LIGHT = 2'd1,
        MAP_PIN   = 2'd2
    } map_phase_t;

    typedef enum logic [4:0] {
        EV_SET_PROMPT  = 5'd0,
        EV_SET_LIGHT   = 5'd1,
        EV_NIBBLE_OK   = 5'd2,
        EV_SET_ERROR   = 5'd3,
        EV_BRIGHT_WR   = 5'd4,
        EV_MODE_TOGGLE = 5'd5,
        EV_QUERY_LVL   = 5'd6,
        EV_ERR_FLAGS   = 5'd7,
        EV_RESET       = 5'd8,
        EV_CNT_DUMP    = 5'd9,
        EV_RESTART_CNT = 5'd10,
        EV_KILL_ALL    = 5'd11,
        EV_IR_DUMP     = 5'd12,
        EV_HELP        = 5'd13,
        EV_MAP_PROMPT  = 5'd14,
        EV_MAP_LIGHT   = 5'd15,
        EV_MAP_WR      = 5'd16,
        EV_MAP_ERROR   = 5'd17,
        EV_MAP_QUERY   = 5'd18,
        EV_UNKNOWN     = 5'd19
    } event_t;

    localparam logic [7:0] CH_SET     = 8'h73; // s
    localparam logic [7:0] CH_MAP     = 8'h70; // p
    localparam logic [7:0] CH_MODE    = 8'h6D; // m
    localparam logic [7:0] CH_QUERY   = 8'h71; // q
    localparam logic [7:0] CH_ERRF    = 8'h65; // e
    localparam logic [7:0] CH_RESET   = 8'h72; // r
    localparam logic [7:0] CH_CNT     = 8'h63; // c
    localparam logic [7:0] CH_RESTART = 8'h69; // i
    localparam logic [7:0] CH_KILL    = 8'h6B; // k
    localparam logic [7:0] CH_IRDUMP  = 8'h64; // d
    localparam logic [7:0] CH_HELP    = 8'h68; // h
    localparam logic [7:0] CH_MAPQ    = 8'h5B; // [
    localparam logic [7:0] CH_ALL     = 8'h61; // a
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;

    typedef struct packed {
        mode_t      mode;
        set_phase_t set_phase;
        logic [3:0] held_light;   // bit 3: all lights
        logic [3:0] high_nibble;
        map_phase_t map_phase;
        logic [2:0] map_light;
        logic       raw_flag;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:        MODE_CMD,
        set_phase:   SET_IDLE,
        held_light:  4'd0,
        high_nibble: 4'd0,
        map_phase:   MAP_IDLE,
        map_light:   3'd0,
        raw_flag:    1'b0
    };

    typedef struct packed {
        event_t     event_res;
        logic [2:0] light_index;
        logic       all_lights;
        logic [7:0] level_value;
        logic [2:0] pin_number;
        logic       raw_mode;
    } result_t;

    // {valid, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (c >= 8'h30 && c <= 8'h39)
                r = {1'b1, c[3:0]};
            else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
                r = {1'b1, c[3:0] + 4'd9};
            return r;
        end
    endfunction

endpackage

// ----- hdl/lcbp_cmd_if.sv -----
interface lcbp_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/lcbp_res_if.sv -----
interface lcbp_res_if;
    logic       valid;
    logic       ready;
    logic [4:0] event_res;
    logic [2:0] light_index;
    logic       all_lights;
    logic [7:0] level_value;
    logic [2:0] pin_number;
    logic       raw_mode;

    modport source (
        output valid, output event_res, output light_index, output all_lights,
        output level_value, output pin_number, output raw_mode, input ready
    );
    modport sink (
        input valid, input event_res, input light_index, input all_lights,
        input level_value, input pin_number, input raw_mode, output ready
    );
endinterface

// ----- hdl/lcbp_decode.sv -----
module lcbp_decode
    import lcbp_pkg::*;
(
    input  state_t     state_cur,
    input  logic [7:0] rx_byte,
    output state_t     state_next,
    output result_t    result
);

    logic [4:0] hex;
    logic       is_digit;
    logic       is_light;
    logic [7:0] low_part;

    assign hex      = hex_decode(rx_byte);
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_SEVEN);
    assign is_light = is_digit || (rx_byte == CH_ALL);
    assign low_part = state_cur.raw_flag ? rx_byte : {4'd0, hex[3:0]};

    // next state
    always_comb
    begin
        state_next = state_cur;
        unique case (state_cur.mode)
            MODE_SET:
            begin
                case (state_cur.set_phase)
                    SET_HIGH:
                    begin
                        if (hex[4])
                        begin
                            state_next.high_nibble = hex[3:0];
                            state_next.set_phase   = SET_LAST;
                        end
                        else
                        begin
                            state_next.mode      = MODE_CMD;
                            state_next.set_phase = SET_IDLE;
                        end
                    end
                    SET_LAST:
                    begin
                        if (state_cur.raw_flag || hex[4])
                            state_next.high_nibble = 4'd0;
                        state_next.mode      = MODE_CMD;
                        state_next.set_phase = SET_IDLE;
                    end
                    default:
                    begin
                        if (is_light)
                        begin
                            state_next.held_light = (rx_byte == CH_ALL) ? 4'b1000
                                                                        : {1'b0, rx_byte[2:0]};
                            state_next.set_phase  = state_cur.raw_flag ? SET_LAST : SET_HIGH;
                        end
                        else
                        begin
                            state_next.mode      = MODE_CMD;
                            state_next.set_phase = SET_IDLE;
                        end
                    end
                endcase
            end
            MODE_MAP:
            begin
                if (state_cur.map_phase != MAP_PIN && is_digit)
                begin
                    state_next.map_light = rx_byte[2:0];
                    state_next.map_phase = MAP_PIN;
                end
                else
                begin
                    state_next.mode      = MODE_CMD;
                    state_next.map_phase = MAP_IDLE;
                end
            end
            default:
            begin
                case (rx_byte)
                    CH_SET:
                    begin
                        state_next.mode      = MODE_SET;
                        state_next.set_phase = SET_LIGHT;
                    end
                    CH_MAP:
                    begin
                        state_next.mode      = MODE_MAP;
                        state_next.map_phase = MAP_LIGHT;
                    end
                    CH_MODE:  state_next.raw_flag = ~state_cur.raw_flag;
                    CH_RESET: state_next = STATE_RESET;
                    CH_QUERY, CH_ERRF, CH_CNT, CH_RESTART, CH_KILL, CH_IRDUMP,
                    CH_HELP, CH_MAPQ: ;
                    default:  state_next.mode = MODE_CMD;
                endcase
            end
        endcase
    end

    // result
    always_comb
    begin
        result          = '0;
        result.raw_mode = state_next.raw_flag;
        unique case (state_cur.mode)
            MODE_SET:
            begin
                result.light_index = state_cur.held_light[2:0];
                result.all_lights  = state_cur.held_light[3];
                case (state_cur.set_phase)
                    SET_HIGH:
                    begin
                        if (hex[4])
                        begin
                            result.event_res   = EV_NIBBLE_OK;
                            result.level_value = {4'd0, hex[3:0]};
                        end
                        else
                            result.event_res = EV_SET_ERROR;
                    end
                    SET_LAST:
                    begin
                        if (state_cur.raw_flag || hex[4])
                        begin
                            result.event_res   = EV_BRIGHT_WR;
                            result.level_value = {state_cur.high_nibble, 4'd0} + low_part;
                        end
                        else
                            result.event_res = EV_SET_ERROR;
                    end
                    default:
                    begin
                        if (is_light)
                        begin
                            result.event_res   = EV_SET_LIGHT;
                            result.light_index = state_next.held_light[2:0];
                            result.all_lights  = state_next.held_light[3];
                        end
                        else
                        begin
                            result.event_res   = EV_SET_ERROR;
                            result.light_index = 3'd0;
                            result.all_lights  = 1'b0;
                        end
                    end
                endcase
            end
            MODE_MAP:
            begin
                if (state_cur.map_phase == MAP_PIN)
                begin
                    result.light_index = state_cur.map_light;
                    if (is_digit)
                    begin
                        result.event_res  = EV_MAP_WR;
                        result.pin_number = rx_byte[2:0];
                    end
                    else
                        result.event_res = EV_MAP_ERROR;
                end
                else if (is_digit)
                begin
                    result.event_res   = EV_MAP_LIGHT;
                    result.light_index = rx_byte[2:0];
                end
                else
                    result.event_res = EV_MAP_ERROR;
            end
            default:
            begin
                case (rx_byte)
                    CH_SET:     result.event_res = EV_SET_PROMPT;
                    CH_MAP:     result.event_res = EV_MAP_PROMPT;
                    CH_MODE:    result.event_res = EV_MODE_TOGGLE;
                    CH_QUERY:   result.event_res = EV_QUERY_LVL;
                    CH_ERRF:    result.event_res = EV_ERR_FLAGS;
                    CH_RESET:   result.event_res = EV_RESET;
                    CH_CNT:     result.event_res = EV_CNT_DUMP;
                    CH_RESTART: result.event_res = EV_RESTART_CNT;
                    CH_KILL:    result.event_res = EV_KILL_ALL;
                    CH_IRDUMP:  result.event_res = EV_IR_DUMP;
                    CH_HELP:    result.event_res = EV_HELP;
                    CH_MAPQ:    result.event_res = EV_MAP_QUERY;
                    default:
                    begin
                        result.event_res   = EV_UNKNOWN;
                        result.level_value = rx_byte;
                    end
                endcase
            end
        endcase
    end

endmodule

// ----- hdl/light_command_byte_parser_top.sv -----
// Channel  Dir  Payload                                                     Handshake
// cmd      in   rx_byte[7:0]                                                valid/ready
// res      out  event_res, light_index, all_lights, level_value,           valid/ready
//               pin_number, raw_mode
//
// One result beat per command beat, registered and presented in the cycle after acceptance.
// A beat is accepted every cycle; the result register holds one beat and
// cmd.ready falls only while that beat is held by res.ready low.
// Asynchronous active-low reset returns the parser to command level, hex mode.
module light_command_byte_parser_top
    import lcbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lcbp_cmd_if.sink          cmd,
    lcbp_res_if.source        res
);

    state_t  state_reg;
    state_t  state_next;
    result_t result_reg;
    result_t result_next;
    logic    res_valid_reg;
    logic    accept;

    lcbp_decode u_decode (
        .state_cur  (state_reg),
        .rx_byte    (cmd.rx_byte),
        .state_next (state_next),
        .result     (result_next)
    );

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.event_res   = result_reg.event_res;
    assign res.light_index = result_reg.light_index;
    assign res.all_lights  = result_reg.all_lights;
    assign res.level_value = result_reg.level_value;
    assign res.pin_number  = result_reg.pin_number;
    assign res.raw_mode    = result_reg.raw_mode;

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted beat produced no result");

    a_raw_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> result_reg.raw_mode == state_reg.raw_flag)
        else $error("raw_mode out of step with parser state");

    a_write_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && result_reg.event_res == EV_BRIGHT_WR) |-> state_reg.mode == MODE_CMD)
        else $error("brightness write left set parser open");

    a_set_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.set_phase != SET_IDLE |-> state_reg.mode == MODE_SET)
        else $error("set phase active outside set parser");

    a_map_phase_mode: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.map_phase != MAP_IDLE |-> state_reg.mode == MODE_MAP)
        else $error("map phase active outside map parser");

endmodule

// ----- tb/tb_light_command_byte_parser_top.sv -----
`timescale 1ns / 100ps

module tb_light_command_byte_parser_top;
    import lcbp_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 120;
    localparam int CYCLE_LIMIT  = 100000;

    typedef struct {
        logic [7:0] c;
        bit         typed;
        result_t    want;
    } script_row_t;

    logic clk;
    logic rst_n;

    lcbp_cmd_if cmd_ch();
    lcbp_res_if res_ch();

    light_command_byte_parser_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // parser shadow
    mode_t      pmode;
    set_phase_t sphase;
    logic [3:0] held;
    logic [3:0] hinib;
    map_phase_t mphase;
    logic [2:0] mlight;
    logic       raw;

    result_t     pending_res [$];
    script_row_t script [$];

    logic [7:0] command_letters [10] = '{CH_QUERY, CH_ERRF, CH_CNT, CH_RESTART, CH_KILL,
                                         CH_IRDUMP, CH_HELP, CH_MAPQ, CH_MODE, CH_RESET};

    int errors          = 0;
    int bytes_sent      = 0;
    int results_checked = 0;
    int stall_cycles    = 0;
    int cycles          = 0;
    int holds_issued    = 0;
    int hold_cnt;
    int ev_count [20];
    bit hold_req        = 1'b0;
    bit calm            = 1'b0;
    bit paused          = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic result_t make_res(event_t ev, logic [2:0] li, logic al,
                                         logic [7:0] lv, logic [2:0] pin, logic rm);
        result_t r;
        r.event_res   = ev;
        r.light_index = li;
        r.all_lights  = al;
        r.level_value = lv;
        r.pin_number  = pin;
        r.raw_mode    = rm;
        return r;
    endfunction

    function automatic void clear_parser();
        pmode  = MODE_CMD;
        sphase = SET_IDLE;
        held   = 4'd0;
        hinib  = 4'd0;
        mphase = MAP_IDLE;
        mlight = 3'd0;
        raw    = 1'b0;
    endfunction

    function automatic int hex_val(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return int'(c - 8'h30);
        if (c >= 8'h61 && c <= 8'h66)
            return int'(c - 8'h57);
        if (c >= 8'h41 && c <= 8'h46)
            return int'(c - 8'h37);
        return -1;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] c);
        result_t    r;
        event_t     ev;
        int         d;
        logic [2:0] li;
        logic       al;
        logic       dig;
        logic [7:0] lv;
        li  = held[2:0];
        al  = held[3];
        dig = (c >= CH_ZERO && c <= CH_SEVEN);
        lv  = 8'd0;
        case (pmode)
            MODE_SET:
            begin
                if (sphase == SET_HIGH || sphase == SET_LAST)
                begin
                    d = (sphase == SET_LAST && raw) ? int'(c) : hex_val(c);
                    if (d < 0)
                    begin
                        pmode  = MODE_CMD;
                        sphase = SET_IDLE;
                        r = make_res(EV_SET_ERROR, li, al, 8'd0, 3'd0, raw);
                    end
                    else if (sphase == SET_HIGH)
                    begin
                        hinib  = d[3:0];
                        sphase = SET_LAST;
                        r = make_res(EV_NIBBLE_OK, li, al, d[7:0], 3'd0, raw);
                    end
                    else
                    begin
                        // high digit left over from a failed write still counts here
                        lv     = {hinib, 4'h0} + d[7:0];
                        hinib  = 4'd0;
                        pmode  = MODE_CMD;
                        sphase = SET_IDLE;
                        r = make_res(EV_BRIGHT_WR, li, al, lv, 3'd0, raw);
                    end
                end
                else if (c == CH_ALL || dig)
                begin
                    held   = (c == CH_ALL) ? 4'b1000 : {1'b0, c[2:0]};
                    sphase = raw ? SET_LAST : SET_HIGH;
                    r = make_res(EV_SET_LIGHT, held[2:0], held[3], 8'd0, 3'd0, raw);
                end
                else
                begin
                    pmode  = MODE_CMD;
                    sphase = SET_IDLE;
                    r = make_res(EV_SET_ERROR, 3'd0, 1'b0, 8'd0, 3'd0, raw);
                end
            end
            MODE_MAP:
            begin
                if (mphase == MAP_PIN)
                begin
                    pmode  = MODE_CMD;
                    mphase = MAP_IDLE;
                    if (dig)
                        r = make_res(EV_MAP_WR, mlight, 1'b0, 8'd0, c[2:0], raw);
                    else
                        r = make_res(EV_MAP_ERROR, mlight, 1'b0, 8'd0, 3'd0, raw);
                end
                else if (dig)
                begin
                    mlight = c[2:0];
                    mphase = MAP_PIN;
                    r = make_res(EV_MAP_LIGHT, mlight, 1'b0, 8'd0, 3'd0, raw);
                end
                else
                begin
                    pmode  = MODE_CMD;
                    mphase = MAP_IDLE;
                    r = make_res(EV_MAP_ERROR, 3'd0, 1'b0, 8'd0, 3'd0, raw);
                end
            end
            default:
            begin
                case (c)
                    CH_SET:
                    begin
                        pmode  = MODE_SET;
                        sphase = SET_LIGHT;
                        ev     = EV_SET_PROMPT;
                    end
                    CH_MAP:
                    begin
                        pmode  = MODE_MAP;
                        mphase = MAP_LIGHT;
                        ev     = EV_MAP_PROMPT;
                    end
                    CH_MODE:
                    begin
                        raw = ~raw;
                        ev  = EV_MODE_TOGGLE;
                    end
                    CH_RESET:
                    begin
                        clear_parser();
                        ev = EV_RESET;
                    end
                    CH_QUERY:   ev = EV_QUERY_LVL;
                    CH_ERRF:    ev = EV_ERR_FLAGS;
                    CH_CNT:     ev = EV_CNT_DUMP;
                    CH_RESTART: ev = EV_RESTART_CNT;
                    CH_KILL:    ev = EV_KILL_ALL;
                    CH_IRDUMP:  ev = EV_IR_DUMP;
                    CH_HELP:    ev = EV_HELP;
                    CH_MAPQ:    ev = EV_MAP_QUERY;
                    default:
                    begin
                        pmode = MODE_CMD;
                        ev    = EV_UNKNOWN;
                        lv    = c;
                    end
                endcase
                r = make_res(ev, 3'd0, 1'b0, lv, 3'd0, raw);
            end
        endcase
        return r;
    endfunction

    function automatic void fixed_row(logic [7:0] c, event_t ev, logic [7:0] lv, logic rm);
        script_row_t row;
        row.c     = c;
        row.typed = 1'b1;
        row.want  = make_res(ev, 3'd0, 1'b0, lv, 3'd0, rm);
        script.push_back(row);
    endfunction

    function automatic void free_row(logic [7:0] c);
        script_row_t row;
        row.c     = c;
        row.typed = 1'b0;
        row.want  = result_t'(0);
        script.push_back(row);
    endfunction

    // byte choice that keeps an open set or map command mostly well formed
    function automatic logic [7:0] next_sub_byte();
        logic [7:0] c;
        int         n;
        c = 8'($urandom_range(0, 255));
        if (pmode == MODE_MAP)
        begin
            if ($urandom_range(0, 99) < 88)
                c = CH_ZERO + 8'($urandom_range(0, 7));
        end
        else if (sphase == SET_HIGH || (sphase == SET_LAST && !raw))
        begin
            if ($urandom_range(0, 99) < 88)
            begin
                n = $urandom_range(0, 21);
                if (n < 10)
                    c = CH_ZERO + 8'(n);
                else if (n < 16)
                    c = CH_ALL + 8'(n - 10);
                else
                    c = 8'h41 + 8'(n - 16);
            end
        end
        else if (sphase != SET_LAST && $urandom_range(0, 99) < 88)
        begin
            n = $urandom_range(0, 8);
            c = (n == 8) ? CH_ALL : CH_ZERO + 8'(n);
        end
        return c;
    endfunction

    task automatic send_byte(input logic [7:0] c, input bit typed, input result_t want);
        result_t got;
        if (!calm && !hold_req && $urandom_range(0, 99) < 27)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 27);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.rx_byte <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        got = parse_byte(c);
        pending_res.push_back(typed ? want : got);
        bytes_sent++;
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_byte(CH_SET, 1'b0, result_t'(0));
        else if (pick < 60)
            send_byte(CH_MAP, 1'b0, result_t'(0));
        else if (pick < 85)
            send_byte(command_letters[$urandom_range(0, 9)], 1'b0, result_t'(0));
        else
            send_byte(8'($urandom_range(0, 255)), 1'b0, result_t'(0));
        while (pmode != MODE_CMD)
            send_byte(next_sub_byte(), 1'b0, result_t'(0));
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // result side back-pressure
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                res_ch.ready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    always @(posedge clk)
    begin : res_check
        result_t want;
        if (rst_n && cmd_ch.valid && !cmd_ch.ready)
            stall_cycles++;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_res.size() == 0)
            begin
                $error("result beat with nothing expected: event_res %0d",
                       res_ch.event_res);
                errors++;
            end
            else
            begin
                want = pending_res.pop_front();
                results_checked++;
                ev_count[want.event_res]++;
                cmp_field("event_res", 8'(want.event_res), 8'(res_ch.event_res));
                cmp_field("light_index", 8'(want.light_index), 8'(res_ch.light_index));
                cmp_field("all_lights", 8'(want.all_lights), 8'(res_ch.all_lights));
                cmp_field("level_value", want.level_value, res_ch.level_value);
                cmp_field("pin_number", 8'(want.pin_number), 8'(res_ch.pin_number));
                cmp_field("raw_mode", 8'(want.raw_mode), 8'(res_ch.raw_mode));
            end
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        cmd_ch.valid   <= 1'b0;
        cmd_ch.rx_byte <= 8'h00;
        rst_n          <= 1'b0;
        clear_parser();
        foreach (ev_count[i])
            ev_count[i] = 0;

        fixed_row(8'h00, EV_UNKNOWN, 8'h00, 1'b0);
        fixed_row(8'hFF, EV_UNKNOWN, 8'hFF, 1'b0);
        fixed_row(CH_QUERY, EV_QUERY_LVL, 8'h00, 1'b0);
        fixed_row(CH_ERRF, EV_ERR_FLAGS, 8'h00, 1'b0);
        fixed_row(CH_CNT, EV_CNT_DUMP, 8'h00, 1'b0);
        fixed_row(CH_RESTART, EV_RESTART_CNT, 8'h00, 1'b0);
        fixed_row(CH_KILL, EV_KILL_ALL, 8'h00, 1'b0);
        fixed_row(CH_IRDUMP, EV_IR_DUMP, 8'h00, 1'b0);
        fixed_row(CH_HELP, EV_HELP, 8'h00, 1'b0);
        fixed_row(CH_MAPQ, EV_MAP_QUERY, 8'h00, 1'b0);
        // failed hex write leaves 'F' behind for the raw write that follows
        fixed_row(CH_SET, EV_SET_PROMPT, 8'h00, 1'b0);
        free_row(CH_SEVEN);
        free_row(8'h46);
        free_row(8'h78);
        fixed_row(CH_MODE, EV_MODE_TOGGLE, 8'h00, 1'b1);
        fixed_row(CH_SET, EV_SET_PROMPT, 8'h00, 1'b1);
        free_row(CH_ALL);
        free_row(8'hFF);
        fixed_row(CH_MAP, EV_MAP_PROMPT, 8'h00, 1'b1);
        free_row(CH_ZERO);
        free_row(CH_SEVEN);
        fixed_row(CH_MAP, EV_MAP_PROMPT, 8'h00, 1'b1);
        fixed_row(8'h39, EV_MAP_ERROR, 8'h00, 1'b1);
        fixed_row(CH_SET, EV_SET_PROMPT, 8'h00, 1'b1);
        fixed_row(8'h7A, EV_SET_ERROR, 8'h00, 1'b1);
        fixed_row(CH_RESET, EV_RESET, 8'h00, 1'b0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_byte(script[i].c, script[i].typed, script[i].want);
        drain();

        while (bytes_sent < script.size() + RANDOM_ITEMS)
        begin
            if ((holds_issued == 0 && bytes_sent >= 150) ||
                (holds_issued == 1 && bytes_sent >= 600))
            begin
                hold_req = 1'b1;
                holds_issued++;
            end
            if (!paused && bytes_sent >= 330)
            begin
                drain();
                paused = 1'b1;
            end
            calm = (bytes_sent >= 450 && bytes_sent < 570);
            random_sequence();
        end
        calm = 1'b0;
        drain();

        $display("%0d bytes sent, %0d result beats checked: %0d brightness writes, %0d map writes,",
                 bytes_sent, results_checked, ev_count[EV_BRIGHT_WR], ev_count[EV_MAP_WR]);
        $display("%0d set errors, %0d map errors, %0d unknown bytes, %0d input stall cycles.",
                 ev_count[EV_SET_ERROR], ev_count[EV_MAP_ERROR], ev_count[EV_UNKNOWN],
                 stall_cycles);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
